FILE: rtl/sprite_scanline_evaluation_unit_macros.svh
// assertion macros shared by the sprite scanline evaluation rtl
`ifndef SPRITE_SCANLINE_EVALUATION_UNIT_MACROS_SVH
`define SPRITE_SCANLINE_EVALUATION_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SSEV_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SSEV_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ssev_pkg.sv
// types and constants for the sprite scanline evaluation unit
package ssev_pkg;

    localparam int CMD_W  = 2;
    localparam int ADDR_W = 8;
    localparam int BYTE_W = 8;
    localparam int LINE_W = 8;
    localparam int NUM_W  = 6;
    localparam int SLOT_W = 3;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam int ENTRY_BYTES  = 4;
    localparam int ENTRY_SHIFT  = 2;
    localparam int SHORT_EXTENT = 7;
    localparam int TALL_EXTENT  = 15;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRAP,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctrl_t;

endpackage

FILE: rtl/ssev_sprite_mem.sv
// sprite attribute memory: one write port, one registered read port
module ssev_sprite_mem
    import ssev_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic              clk,
    input  mem_ctrl_t         ctrl,
    input  logic [AW-1:0]     waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] ram_reg [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            ram_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sprite_scanline_evaluation_unit.sv
// top level of the sprite scanline evaluation unit
//
//   channel   handshake               payload
//   -------   ---------------------   ----------------------------------------------
//   input     in_valid / in_ready     command, mem_address, mem_byte, scanline
//   output    out_valid / out_ready   found, sprite_number, slot, overflow, last
//   config    cfg_valid / cfg_ready   tall_sprites
//
// evaluate: scan of the entries, ended early by overflow (one y byte per cycle through the
//   single memory read port), then the result transactions, paced by out_ready
// write: the address is wrapped by repeated subtraction of MEMORY_BYTES, then written
// clear overflow and unused command: done in the idle state, no further state
// one transaction at a time: in_ready is high only in idle; out_valid holds until taken
// reset (rst_n low, asynchronous) clears control state and the overflow flag; the
//   sprite memory itself is not cleared and needs no clearing pass

`include "sprite_scanline_evaluation_unit_macros.svh"

module sprite_scanline_evaluation_unit
    import ssev_pkg::*;
#(
    parameter int MEMORY_BYTES     = 256,
    parameter int SPRITES_PER_LINE = 8
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  command,
    input  logic [ADDR_W-1:0] mem_address,
    input  logic [BYTE_W-1:0] mem_byte,
    input  logic [LINE_W-1:0] scanline,

    output logic              out_valid,
    input  logic              out_ready,
    output logic              found,
    output logic [NUM_W-1:0]  sprite_number,
    output logic [SLOT_W-1:0] slot,
    output logic              overflow,
    output logic              last,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              tall_sprites
);

    localparam int ENTRY_COUNT = MEMORY_BYTES / ENTRY_BYTES;
    localparam int AW = $clog2(MEMORY_BYTES);
    localparam int EW = $clog2(ENTRY_COUNT);
    localparam int CW = $clog2(ENTRY_COUNT + 1);
    localparam int NW = $clog2(SPRITES_PER_LINE + 1);
    localparam int SW = (SPRITES_PER_LINE > 1) ? $clog2(SPRITES_PER_LINE) : 1;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [EW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [NW-1:0]     count_reg, count_next;
    logic [NW-1:0]     emit_idx_reg, emit_idx_next;
    logic              ovf_reg, ovf_next;
    logic              tall_reg;

    // sprite numbers found on the current line, in slot order
    logic [EW-1:0]     nums_reg [SPRITES_PER_LINE];
    logic              nums_we;

    mem_ctrl_t         mem_ctrl;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] y_byte;

    logic              issue;
    logic              hit;
    logic [LINE_W:0]   y_ext;
    logic [LINE_W:0]   y_bottom;

    ssev_sprite_mem #(
        .DEPTH (MEMORY_BYTES),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .ctrl  (mem_ctrl),
        .waddr (mem_waddr),
        .wdata (byte_reg),
        .raddr (mem_raddr),
        .rdata (y_byte)
    );

    // address has already been wrapped below MEMORY_BYTES when written
    assign mem_waddr = AW'(addr_reg);
    // y byte sits at the start of each four-byte entry
    assign mem_raddr = AW'({rd_idx_reg[EW-1:0], {ENTRY_SHIFT{1'b0}}});

    // shared range compare: y <= line and y + extent >= line, no wrap on the sum
    assign y_ext    = tall_reg ? (LINE_W+1)'(TALL_EXTENT) : (LINE_W+1)'(SHORT_EXTENT);
    assign y_bottom = {1'b0, y_byte} + y_ext;
    assign hit      = (y_byte <= line_reg) && (y_bottom >= {1'b0, line_reg});

    // the compare sees each read in the cycle after it is issued
    assign issue = (int'(rd_idx_reg) < ENTRY_COUNT);

    // config register, single bit, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tall_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tall_reg <= tall_sprites;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            count_reg     <= '0;
            emit_idx_reg  <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            count_reg     <= count_next;
            emit_idx_reg  <= emit_idx_next;
            ovf_reg       <= ovf_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        byte_reg    <= byte_next;
        line_reg    <= line_next;
        cmp_idx_reg <= cmp_idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (nums_we)
        begin
            nums_reg[count_reg[SW-1:0]] <= cmp_idx_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        byte_next      = byte_reg;
        line_next      = line_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        count_next     = count_reg;
        emit_idx_next  = emit_idx_reg;
        ovf_next       = ovf_reg;
        mem_ctrl       = '0;
        nums_we        = 1'b0;
        in_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (command)
                        CMD_WRITE:
                        begin
                            addr_next  = mem_address;
                            byte_next  = mem_byte;
                            state_next = ST_WRAP;
                        end
                        CMD_EVAL:
                        begin
                            line_next      = scanline;
                            rd_idx_next    = '0;
                            cmp_valid_next = 1'b0;
                            count_next     = '0;
                            state_next     = ST_SCAN;
                        end
                        CMD_CLEAR:
                        begin
                            ovf_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_WRAP:
            begin
                // address modulo memory size, one subtraction per cycle
                if (int'(addr_reg) >= MEMORY_BYTES)
                begin
                    addr_next = addr_reg - ADDR_W'(MEMORY_BYTES);
                end
                else
                begin
                    mem_ctrl.wr_en = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                mem_ctrl.rd_en = issue;
                cmp_valid_next = issue;
                cmp_idx_next   = rd_idx_reg[EW-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end

                if (cmp_valid_reg && hit)
                begin
                    if (int'(count_reg) == SPRITES_PER_LINE)
                    begin
                        // one sprite too many: flag and stop, drop the read in flight
                        ovf_next       = 1'b1;
                        cmp_valid_next = 1'b0;
                        emit_idx_next  = '0;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        nums_we    = 1'b1;
                        count_next = count_reg + NW'(1);
                    end
                end
                else if (!issue && !cmp_valid_reg)
                begin
                    emit_idx_next = '0;
                    state_next    = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + NW'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result fields, all from registers; the flag is final once the scan ends
    assign out_valid     = (state_reg == ST_EMIT);
    assign found         = (count_reg != '0);
    assign sprite_number = found ? NUM_W'(nums_reg[emit_idx_reg[SW-1:0]]) : '0;
    assign slot          = SLOT_W'(emit_idx_reg);
    assign overflow      = ovf_reg;
    assign last          = !found || ((emit_idx_reg + NW'(1)) == count_reg);

    `SSEV_ASSERT_IMP(a_ready_not_valid, in_ready, !out_valid, "input ready while a result waits")
    `SSEV_ASSERT_IMP(a_cmp_in_scan, cmp_valid_reg, state_reg == ST_SCAN, "compare stage live outside scan")
    `SSEV_ASSERT_IMP(a_ovf_when_full, $rose(ovf_reg), int'(count_reg) == SPRITES_PER_LINE, "overflow set before slots full")
    `SSEV_ASSERT_NXT(a_last_to_idle, out_valid && out_ready && last, in_ready, "not ready after last result")

endmodule
